/* rtl/core/sle_pkg.sv */
package sle_pkg;

   // Operation codes carried by req_mode
   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_LOCATE = 2'd2
   } sle_mode_type;

   // Result status codes carried by rsp_status
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } sle_status_type;

   // Sequencer states
   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_FIND = 1'b1
   } sle_state_type;

   // Broadcast command to every cell of the chain
   typedef struct packed {
      logic ins;   // shift up from the insert point, load the new word there
      logic del;   // shift down from the delete point
      logic cmp;   // compare against the search word
   } sle_cell_cmd_type;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned FIELD_W = 7;

endpackage

/* rtl/core/sle_cell.sv */
module sle_cell #(
   parameter int unsigned IDX = 0,
   parameter int unsigned IW = 6,
   parameter int unsigned CW = 7
) (
   input  logic                                   clock,
   input  sle_pkg::sle_cell_cmd_type              cmd,
   input  logic [IW-1:0]                          pos_idx,
   input  logic [CW-1:0]                          count,
   input  logic signed [sle_pkg::DATA_W-1:0]      value,
   input  logic signed [sle_pkg::DATA_W-1:0]      left_entry,
   input  logic signed [sle_pkg::DATA_W-1:0]      right_entry,
   output logic signed [sle_pkg::DATA_W-1:0]      entry,
   output logic                                   match
);
   import sle_pkg::*;

   localparam logic [IW-1:0] IDX_I = IW'(IDX);
   localparam logic [CW-1:0] IDX_C = CW'(IDX);

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;
   logic                     match_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins) begin
         if (IDX_I > pos_idx) entry_in = left_entry;
         else if (IDX_I == pos_idx) entry_in = value;
      end else if (cmd.del) begin
         if (IDX_I >= pos_idx) entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (cmd.cmp) match_ff <= (entry_ff == value) && (IDX_C < count);
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

/* rtl/core/sle_first_match.sv */
module sle_first_match #(
   parameter int unsigned CAPACITY = 64,
   parameter int unsigned CW = 7
) (
   input  logic [CAPACITY-1:0] match,
   output logic [CW-1:0]       found
);
   import sle_pkg::*;

   logic [CAPACITY-1:0] prefix;
   logic [CAPACITY-1:0] first;

   // prefix[i] is set when any match exists at or below i; log-depth OR tree
   always_comb begin
      prefix = match;
      for (int s = 1; s < CAPACITY; s = s * 2) begin
         prefix = prefix | (prefix << s);
      end
   end

   assign first = match & ~(prefix << 1);

   always_comb begin
      found = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (first[i]) found = found | CW'(i + 1);
      end
   end

endmodule

/* rtl/core/sequential_list_engine.sv */
// Ordered list engine: insert at position, delete at position, locate by value.
// An accepted word moves the sequencer to find; the response loads from find once
// the response slot is free or draining, and no word is taken until that load.
// Cells shift or compare on accept; the first-match encoder works in find.
// Reset clears the entry count, sequencer and response valid; cell contents hold.
module sequential_list_engine #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_mode,
   input  logic [sle_pkg::FIELD_W-1:0]         req_position,
   input  logic signed [sle_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [sle_pkg::FIELD_W-1:0]         rsp_found_position,
   output logic [sle_pkg::FIELD_W-1:0]         rsp_count
);
   import sle_pkg::*;

   localparam int unsigned IW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   // width that holds both a 7-bit position and a count with headroom
   localparam int unsigned XW = CW + FIELD_W;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   // Sequencer and response registers
   sle_state_type           state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   sle_status_type          status_ff, status_in;
   logic                    locate_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [FIELD_W-1:0]      rsp_found_ff, rsp_found_in;
   logic [FIELD_W-1:0]      rsp_count_ff, rsp_count_in;

   logic                    accept;
   logic                    load_rsp;
   logic                    op_ok;
   sle_mode_type            mode;
   logic [XW-1:0]           pos_ext;
   logic [XW-1:0]           cnt_ext;
   logic [XW-1:0]           pos_less1;
   logic [IW-1:0]           pos_idx;
   sle_cell_cmd_type        cmd;

   logic signed [DATA_W-1:0] entries [CAPACITY];
   logic [CAPACITY-1:0]      match;
   logic [CW-1:0]            found;
   logic [XW-1:0]            found_ext;
   logic [XW-1:0]            count_ext;

   assign req_ready = (state_ff == FSM_IDLE);
   assign accept    = req_valid && req_ready;
   assign mode      = sle_mode_type'(req_mode);

   assign pos_ext   = {{CW{1'b0}}, req_position};
   assign cnt_ext   = {{FIELD_W{1'b0}}, count_ff};
   assign pos_less1 = pos_ext - XW'(1);
   // only used when the position is in range, so pos-1 fits the cell index
   assign pos_idx   = pos_less1[IW-1:0];

   // Decode the operation; range-check insert/delete positions, flag a full list on insert
   always_comb begin
      status_in = ST_OK;
      count_in  = count_ff;
      op_ok     = 1'b0;
      unique case (mode)
         MODE_INSERT: begin
            if (req_position == '0 || pos_ext > cnt_ext + XW'(1)) begin
               status_in = ST_RANGE;
            end else if (count_ff == CAP_C) begin
               status_in = ST_FULL;
            end else begin
               op_ok    = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         MODE_DELETE: begin
            if (req_position == '0 || pos_ext > cnt_ext) begin
               status_in = ST_RANGE;
            end else begin
               op_ok    = 1'b1;
               count_in = count_ff - CW'(1);
            end
         end
         MODE_LOCATE: begin
            op_ok = 1'b1;
         end
         default: begin
            status_in = ST_RANGE;
         end
      endcase
   end

   // Broadcast to the chain only for accepted words that pass the range and full checks
   always_comb begin
      cmd.ins = accept && op_ok && (mode == MODE_INSERT);
      cmd.del = accept && op_ok && (mode == MODE_DELETE);
      cmd.cmp = accept && (mode == MODE_LOCATE);
   end

   // Chain of cells: each holds one entry and trades it with its neighbors
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic signed [DATA_W-1:0] left_entry;
      logic signed [DATA_W-1:0] right_entry;

      if (k == 0) begin : g_head
         assign left_entry = req_value;      // never selected for the head cell
      end else begin : g_body
         assign left_entry = entries[k-1];
      end

      if (k == CAPACITY - 1) begin : g_tail
         assign right_entry = entries[k];    // top slot falls out of range on delete
      end else begin : g_mid
         assign right_entry = entries[k+1];
      end

      sle_cell #(
         .IDX (k),
         .IW  (IW),
         .CW  (CW)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .pos_idx     (pos_idx),
         .count       (count_ff),
         .value       (req_value),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entries[k]),
         .match       (match[k])
      );
   end

   // Lowest matching position, from the match flags the cells registered
   sle_first_match #(
      .CAPACITY (CAPACITY),
      .CW       (CW)
   ) u_first_match (
      .match (match),
      .found (found)
   );

   assign found_ext = {{FIELD_W{1'b0}}, found};
   assign count_ext = {{FIELD_W{1'b0}}, count_ff};

   // Load the response slot once it is free or being drained
   assign load_rsp = (state_ff == FSM_FIND) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) state_in = FSM_FIND;
         end
         FSM_FIND: begin
            if (load_rsp) begin
               state_in      = FSM_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_found_in  = locate_ff ? found_ext[FIELD_W-1:0] : '0;
               rsp_count_in  = count_ext[FIELD_W-1:0];
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) count_ff <= count_in;
      end
   end

   // Payload: hold the decoded status until the response is built
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         locate_ff <= (mode == MODE_LOCATE);
      end
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_count          = rsp_count_ff;

endmodule
